FILE: sv/timeout_slot_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the timeout slot table
// Shared wrappers that keep clock and reset handling uniform.
// ---------------------------------------------------------------------------
`ifndef TIMEOUT_SLOT_TABLE_ASSERT_SVH
`define TIMEOUT_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timeout slot table: implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timeout slot table: next-cycle check failed");

`endif

FILE: sv/tst_pkg.sv
// ---------------------------------------------------------------------------
// Timeout slot table package
// Shared constants, codes and types of the timeout slot table.
// ---------------------------------------------------------------------------
package tst_pkg;

  // Default table size and the cap on expiry beats per tick.
  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  // Widths of the item fields.
  localparam int TICKS_W = 32;
  localparam int TAG_W   = 32;

  // Input command codes (carried on s_tuser).
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Result kind codes (carried on m_tuser).
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_SCAN,
    ST_REG_DONE,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_TICK_FLUSH
  } state_t;

  // Write enables of the slot memory.
  typedef struct packed {
    logic rem;
    logic tag;
  } mem_we_t;

endpackage

FILE: sv/tst_slot_mem.sv
// ---------------------------------------------------------------------------
// Timeout slot memory
// Remaining-tick and tag storage, one write port and one registered read.
// ---------------------------------------------------------------------------
module tst_slot_mem #(
  parameter int SLOTS = tst_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk,
  input  tst_pkg::mem_we_t           we,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [tst_pkg::TICKS_W-1:0] wr_rem,
  input  logic [tst_pkg::TAG_W-1:0]   wr_tag,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [tst_pkg::TICKS_W-1:0] rd_rem,
  output logic [tst_pkg::TAG_W-1:0]   rd_tag
);

  logic [tst_pkg::TICKS_W-1:0] rem_mem [SLOTS];
  logic [tst_pkg::TAG_W-1:0]   tag_mem [SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we.rem) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (we.tag) begin
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_rem <= rem_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

endmodule

FILE: sv/timeout_slot_table.sv
// ---------------------------------------------------------------------------
// Timeout slot table
// Fixed table of one-shot timeouts with registration and tick scanning.
// ---------------------------------------------------------------------------
// Usage: the slave channel takes one command beat. s_tuser selects register
// (claim the lowest free slot with delay and tag) or tick (one millisecond
// elapsed). A register beat returns one status beat on the master channel,
// with tlast set. A tick returns one expiry beat per slot that runs out, up
// to MAX_RESULTS, in ascending slot order, tlast on the final one; a tick
// with nothing due returns no beat.
// A register beat scans the busy bits one slot per cycle. In a tick, each
// slot goes through the single memory read port and then one update step.
// s_tready is high only while the sequencer is idle; one command at a time,
// so the next command is taken only once the sequencer is idle again.
// A synchronous reset frees every slot and empties the output register.
// A stalled receiver holds the output register; the scan waits on the next
// due slot until the held beat is taken, so no beat is dropped.
// ---------------------------------------------------------------------------
module timeout_slot_table #(
  parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [31:0] delay_ticks, [63:32] tag
  input  logic        s_tuser,  // [0] cmd
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] expired_tag, [32] accepted, [39:33] zero
  output logic        m_tuser,  // [0] kind
  output logic        m_tlast   // last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(tst_pkg::MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(tst_pkg::MAX_RESULTS);

  tst_pkg::state_t state, state_next;

  logic [SLOTS-1:0]             busy;
  logic [IDX_W-1:0]             idx;
  logic [CNT_W-1:0]             n_emit;
  logic [tst_pkg::TICKS_W-1:0]  in_rem;
  logic [tst_pkg::TAG_W-1:0]    in_tag;
  logic                         reg_ok;

  logic                         pend_valid;
  logic [tst_pkg::TAG_W-1:0]    pend_tag;

  logic                         out_valid;
  logic                         out_kind;
  logic [tst_pkg::TAG_W-1:0]    out_tag;
  logic                         out_acc;
  logic                         out_last;

  tst_pkg::mem_we_t             mem_we;
  logic [tst_pkg::TICKS_W-1:0]  mem_wr_rem;
  logic [tst_pkg::TICKS_W-1:0]  rd_rem;
  logic [tst_pkg::TAG_W-1:0]    rd_tag;

  logic in_fire;
  logic out_free;
  logic slot_free;
  logic due;
  logic emit;
  logic stall;
  logic load_status;
  logic load_mid;
  logic load_final;
  logic load_any;

  // Slot storage.
  tst_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (idx),
    .wr_rem  (mem_wr_rem),
    .wr_tag  (in_tag),
    .rd_addr (idx),
    .rd_rem  (rd_rem),
    .rd_tag  (rd_tag)
  );

  // Handshake and per-slot conditions.
  assign s_tready  = (state == tst_pkg::ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign slot_free = !busy[idx];
  assign due       = busy[idx] && (rd_rem < tst_pkg::TICKS_W'(2));
  assign emit      = due && (n_emit < CNT_MAX);
  assign stall     = emit && pend_valid && !out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tst_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (s_tuser == tst_pkg::CMD_TICK) ? tst_pkg::ST_TICK_RD
                                                      : tst_pkg::ST_REG_SCAN;
        end
      end
      tst_pkg::ST_REG_SCAN: begin
        if (slot_free || idx == IDX_END) begin
          state_next = tst_pkg::ST_REG_DONE;
        end
      end
      tst_pkg::ST_REG_DONE: begin
        if (out_free) begin
          state_next = tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_TICK_RD: begin
        state_next = tst_pkg::ST_TICK_EVAL;
      end
      tst_pkg::ST_TICK_EVAL: begin
        if (!stall) begin
          state_next = (idx == IDX_END) ? tst_pkg::ST_TICK_FLUSH : tst_pkg::ST_TICK_RD;
        end
      end
      tst_pkg::ST_TICK_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = tst_pkg::ST_IDLE;
        end
      end
      default: state_next = tst_pkg::ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    mem_we      = '0;
    mem_wr_rem  = in_rem;
    load_status = 1'b0;
    load_mid    = 1'b0;
    load_final  = 1'b0;
    unique case (state)
      tst_pkg::ST_REG_SCAN: begin
        mem_we.rem = slot_free;
        mem_we.tag = slot_free;
      end
      tst_pkg::ST_REG_DONE: begin
        load_status = out_free;
      end
      tst_pkg::ST_TICK_EVAL: begin
        if (!stall) begin
          load_mid = emit && pend_valid;
          // Overdue slots beyond the cap wait at one tick; others count down.
          if (busy[idx] && !due) begin
            mem_we.rem = 1'b1;
            mem_wr_rem = rd_rem - tst_pkg::TICKS_W'(1);
          end else if (due && !emit) begin
            mem_we.rem = 1'b1;
            mem_wr_rem = tst_pkg::TICKS_W'(1);
          end
        end
      end
      tst_pkg::ST_TICK_FLUSH: begin
        load_final = pend_valid && out_free;
      end
      default: ;
    endcase
  end

  assign load_any = load_status || load_mid || load_final;

  // Sequencer and slot bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tst_pkg::ST_IDLE;
      busy       <= '0;
      idx        <= '0;
      n_emit     <= '0;
      reg_ok     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        tst_pkg::ST_IDLE: begin
          idx        <= '0;
          n_emit     <= '0;
          reg_ok     <= 1'b0;
          pend_valid <= 1'b0;
        end
        tst_pkg::ST_REG_SCAN: begin
          if (slot_free) begin
            busy[idx] <= 1'b1;
            reg_ok    <= 1'b1;
          end else if (idx != IDX_END) begin
            idx <= idx + IDX_W'(1);
          end
        end
        tst_pkg::ST_TICK_EVAL: begin
          if (!stall) begin
            if (emit) begin
              busy[idx]  <= 1'b0;
              pend_valid <= 1'b1;
              n_emit     <= n_emit + CNT_W'(1);
            end
            if (idx != IDX_END) begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        tst_pkg::ST_TICK_FLUSH: begin
          if (load_final) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Captured command payload and the held expiry tag.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_rem <= s_tdata[31:0];
      in_tag <= s_tdata[63:32];
    end
    if (state == tst_pkg::ST_TICK_EVAL && emit && !stall) begin
      pend_tag <= rd_tag;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_kind <= tst_pkg::KIND_STATUS;
      out_tag  <= '0;
      out_acc  <= reg_ok;
      out_last <= 1'b1;
    end else if (load_any) begin
      out_kind <= tst_pkg::KIND_EXPIRY;
      out_tag  <= pend_tag;
      out_acc  <= 1'b0;
      out_last <= load_final;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_acc, out_tag};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Checks.
  `include "timeout_slot_table_assert.svh"

  `TST_ASSERT_IMP(a_no_overwrite, load_any, out_free)
  `TST_ASSERT_IMP(a_idle_no_pend, state == tst_pkg::ST_IDLE, !pend_valid)
  `TST_ASSERT_IMP(a_cap, 1'b1, n_emit <= CNT_MAX)
  `TST_ASSERT_IMP(a_status_form, out_valid && out_kind == tst_pkg::KIND_STATUS,
                  out_last && out_tag == '0)
  `TST_ASSERT_NXT(a_emit_frees, state == tst_pkg::ST_TICK_EVAL && emit && !stall,
                  pend_valid)

endmodule

FILE: tb/timeout_slot_table_checker.sv
// ---------------------------------------------------------------------------
// Timeout slot table checker
// Watches both stream channels of the timeout slot table. Every command beat
// it sees accepted is run through a slot-table predictor, and every result
// beat is compared field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module timeout_slot_table_checker #(
  parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [63:0]        s_tdata,   // [31:0] delay_ticks, [63:32] tag
  input  logic               s_tuser,   // [0] cmd
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [39:0]        m_tdata,   // [31:0] expired_tag, [32] accepted
  input  logic               m_tuser,   // [0] kind
  input  logic               m_tlast,
  output int unsigned        fail_count,
  output int unsigned        pending_count,
  output int unsigned        expiry_count,
  output int unsigned        refused_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result beat.
  typedef struct packed {
    logic                      kind;
    logic [tst_pkg::TAG_W-1:0] tag;
    logic                      accepted;
    logic                      last;
  } result_t;

  // Predicted copy of the slot table.
  logic                        armed      [SLOTS];
  logic [tst_pkg::TICKS_W-1:0] ticks_left [SLOTS];
  logic [tst_pkg::TAG_W-1:0]   owner_tag  [SLOTS];

  // Results predicted but not yet seen on the master channel, oldest first.
  result_t results_due[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    expiry_count  = 0;
    refused_count = 0;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one command to the predicted table and queue the results it causes.
  task automatic predict_command(input logic cmd,
                                 input logic [tst_pkg::TICKS_W-1:0] delay,
                                 input logic [tst_pkg::TAG_W-1:0] tag);
    logic found;
    int   n_due;
    int   last_slot;
    int   n_out;
    found     = 1'b0;
    n_due     = 0;
    last_slot = -1;
    n_out     = 0;
    if (cmd == tst_pkg::CMD_REGISTER) begin
      // Claim the lowest free slot, if any.
      for (int slot = 0; slot < SLOTS; slot++) begin
        if (!armed[slot] && !found) begin
          armed[slot]      = 1'b1;
          ticks_left[slot] = delay;
          owner_tag[slot]  = tag;
          found            = 1'b1;
        end
      end
      if (!found) refused_count++;
      results_due.push_back('{kind: tst_pkg::KIND_STATUS, tag: '0, accepted: found,
                              last: 1'b1});
    end else begin
      // Find the highest slot that reports on this tick, so tlast lands there.
      for (int slot = 0; slot < SLOTS; slot++) begin
        if (armed[slot] && ticks_left[slot] <= 1 && n_due < tst_pkg::MAX_RESULTS) begin
          n_due++;
          last_slot = slot;
        end
      end
      // Report due slots in ascending order up to the cap; capped slots wait at one tick, the rest count down.
      for (int slot = 0; slot < SLOTS; slot++) begin
        if (armed[slot]) begin
          if (ticks_left[slot] <= 1) begin
            if (n_out < tst_pkg::MAX_RESULTS) begin
              results_due.push_back('{kind: tst_pkg::KIND_EXPIRY, tag: owner_tag[slot],
                                      accepted: 1'b0, last: (slot == last_slot)});
              armed[slot] = 1'b0;
              n_out++;
              expiry_count++;
            end else begin
              ticks_left[slot] = 1;
            end
          end else begin
            ticks_left[slot] = ticks_left[slot] - 1;
          end
        end
      end
    end
  endtask

  // Sample both channels at the rising edge; results are checked before the
  // command of the same edge is predicted, since they cannot belong to it.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int slot = 0; slot < SLOTS; slot++) armed[slot] = 1'b0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with nothing expected", m_tdata[31:0], '0);
        end else begin
          want = results_due.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
          if (m_tdata[31:0] !== want.tag)
            report_mismatch("expired_tag", m_tdata[31:0], want.tag);
          if (m_tdata[32] !== want.accepted)
            report_mismatch("accepted", 32'(m_tdata[32]), 32'(want.accepted));
          if (m_tlast !== want.last)
            report_mismatch("last", 32'(m_tlast), 32'(want.last));
        end
      end
      if (s_tvalid && s_tready)
        predict_command(s_tuser, s_tdata[31:0], s_tdata[63:32]);
    end
    pending_count = results_due.size();
  end

endmodule

FILE: tb/tb_timeout_slot_table.sv
// ---------------------------------------------------------------------------
// Timeout slot table testbench
// Drives register and tick commands into the slot table with random gaps
// and random receiver stalls, including a long receiver hold-off and a full
// drain pause. A separate checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb_timeout_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = tst_pkg::SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 356;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_AFTER    = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [31:0] delay_ticks, [63:32] tag
  logic        s_tuser;   // [0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] expired_tag, [32] accepted, [39:33] zero
  logic        m_tuser;   // [0] kind
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned expiry_count;
  int unsigned refused_count;
  int unsigned n_register = 0;
  int unsigned n_tick     = 0;
  int unsigned idle_cycles = 0;
  logic        tx_fast = 1'b0;

  timeout_slot_table #(.SLOTS(SLOTS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  timeout_slot_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .expiry_count  (expiry_count),
    .refused_count (refused_count)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one command beat after a random gap and wait until it is taken.
  task automatic send_command(input logic cmd, input logic [31:0] delay,
                              input logic [31:0] tag);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {tag, delay};
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cmd == tst_pkg::CMD_REGISTER) n_register++;
    else n_tick++;
  endtask

  // A tick carries random bits in the fields it does not use.
  task automatic send_tick();
    send_command(tst_pkg::CMD_TICK, $urandom, $urandom);
  endtask

  // Stop offering beats until every predicted result has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Mostly short delays so slots turn over; a few longer ones linger.
  function automatic logic [31:0] draw_delay();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 4);
    if (pick < 97) return $urandom_range(5, 30);
    return $urandom_range(31, 200);
  endfunction

  function automatic logic [31:0] draw_tag();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Receiver: random stall before each beat, one long hold-off mid-run.
  initial begin
    int          stall;
    int unsigned taken;
    logic        rx_fast;
    taken   = 0;
    rx_fast = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
      if (taken % 16 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      // Hold the result channel long enough for the block to back up.
      if (taken == HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  // Sender: reset, directed commands, random commands, then the verdict.
  initial begin
    int reg_share;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = tst_pkg::CMD_REGISTER;
    reg_share = 50;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A tick on an empty table produces no beat.
    send_tick();
    // Fill every slot with delays of zero and one, then overflow the table.
    for (int slot = 0; slot < SLOTS; slot++)
      send_command(tst_pkg::CMD_REGISTER, 32'(slot % 2), draw_tag());
    send_command(tst_pkg::CMD_REGISTER, 32'h0000_0003, 32'h1234_5678);
    // Every slot comes due on the same tick.
    send_tick();
    // Delay extremes: zero, two, and the largest value.
    send_command(tst_pkg::CMD_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(tst_pkg::CMD_REGISTER, 32'h0000_0002, 32'h0000_0000);
    send_command(tst_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
    send_tick();
    send_tick();

    // Random phases that lean toward registering, ticking, or neither.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 24 == 0) begin
        reg_share = 25 * $urandom_range(1, 3);
        tx_fast   = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < reg_share) begin
        send_command(tst_pkg::CMD_REGISTER, draw_delay(), draw_tag());
      end else begin
        send_tick();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d registrations (%0d refused on a full table) and %0d ticks,",
             n_register, refused_count, n_tick);
    $display("with %0d expiry beats under random gaps, stalls and one long hold-off.",
             expiry_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/tst_pkg.sv
sv/tst_slot_mem.sv
sv/timeout_slot_table.sv
tb/timeout_slot_table_checker.sv
tb/tb_timeout_slot_table.sv
